// ===== src/acsa_pkg.sv =====
// shared constants for the adc channel scan averager
`default_nettype none

package acsa_pkg;

  // default geometry of the block
  localparam int unsigned ChannelsDef   = 8;
  localparam int unsigned SamplesDef    = 4;
  localparam int unsigned SampleBitsDef = 12;

  // fixed field widths of the ports
  localparam int unsigned EnableW = 8;
  localparam int unsigned ConvW   = 12;
  localparam int unsigned ChanW   = 3;
  localparam int unsigned AvgW    = 12;

  // operation codes
  localparam logic OpScan = 1'b0;
  localparam logic OpRead = 1'b1;

endpackage

`default_nettype wire

// ===== src/acsa_sample_store.sv =====
// sample memory with per-entry valid bits so unwritten entries read as zero
`default_nettype none

module acsa_sample_store #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 12,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [Width-1:0] rd_data_q;
  logic             rd_valid_q;

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // storage write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q  <= mem[rd_addr_i];
    rd_valid_q <= valid_q[rd_addr_i];
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== src/adc_channel_scan_averager.sv =====
// adc channel scan sequencer with per-channel sample averaging
`default_nettype none

// Scans the enabled channels in ascending order, one scan tick per request.
// An idle tick picks the lowest enabled channel; a channel then takes
// SAMPLES+1 ticks: the first asks for channel setup and a conversion, the
// rest store converter values and the last moves on to the next higher
// enabled channel or back to idle. A read request returns the truncated mean
// of a channel's stored samples (zero for a channel that does not exist).
// The block takes one request at a time: a scan tick passes through the
// execute and finish states; a read of an existing channel also steps through
// a read and an add state per sample, set by the single read port of the
// sample memory (one sample at a time into the shared accumulator), and a
// divide state that divides the sum by SAMPLES as a multiply by a constant
// reciprocal. A finished result sits in an output register, so the next
// request can be taken while it waits. channel_enable is accepted at any
// cycle and must only change while no request is in flight.
module adc_channel_scan_averager #(
  parameter int unsigned CHANNELS    = acsa_pkg::ChannelsDef,
  parameter int unsigned SAMPLES     = acsa_pkg::SamplesDef,
  parameter int unsigned SAMPLE_BITS = acsa_pkg::SampleBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write channel
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [acsa_pkg::EnableW-1:0] cfg_channel_enable_i,
  // request channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        operation_i,
  input  wire logic [acsa_pkg::ConvW-1:0]  conversion_value_i,
  input  wire logic [acsa_pkg::ChanW-1:0]  read_channel_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             select_channel_o,
  output logic                             start_conversion_o,
  output logic      [acsa_pkg::ChanW-1:0]  active_channel_o,
  output logic                             scan_idle_o,
  output logic      [acsa_pkg::AvgW-1:0]   average_o
);

  import acsa_pkg::*;

  localparam int unsigned Depth  = CHANNELS * SAMPLES;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CurW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned LeftW  = $clog2(SAMPLES + 1);
  localparam int unsigned SumW   = SAMPLE_BITS + $clog2(SAMPLES);
  localparam int unsigned CntW   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  // reciprocal of the sample count, exact for every sum below 2**SumW
  localparam int unsigned DivSh  = SumW + $clog2(SAMPLES);
  localparam int unsigned RecipW = DivSh + 1;
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << DivSh) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

  // sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExec = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StAdd  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [EnableW-1:0]     enable_q;
  logic                   op_q;
  logic [SAMPLE_BITS-1:0] conv_q;
  logic [ChanW-1:0]       rch_q;

  logic [CurW-1:0]        cur_q, cur_d;
  logic                   cur_valid_q, cur_valid_d;
  logic [LeftW-1:0]       left_q, left_d;

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic                   sel_q, sel_d;
  logic                   start_q, start_d;

  logic                   out_valid_q;
  logic                   out_sel_q;
  logic                   out_start_q;
  logic [ChanW-1:0]       out_chan_q;
  logic                   out_idle_q;
  logic [AvgW-1:0]        out_avg_q;

  logic                   in_acc;
  logic                   out_free;
  logic                   out_load;

  logic [CHANNELS-1:0]    live;
  logic                   low_found;
  logic [CurW-1:0]        low_chan;
  logic                   nxt_found;
  logic [CurW-1:0]        nxt_chan;

  logic                   wr_en;
  logic [AddrW-1:0]       wr_addr;
  logic [AddrW-1:0]       rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;

  logic [ProdW-1:0]       prod;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == StFin) && out_free;

  // enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      enable_q <= cfg_channel_enable_i;
    end
  end

  // channels that take part in the scan, bits above the register read as zero
  assign live = CHANNELS'(enable_q);

  // lowest enabled channel, and lowest enabled channel above the current one
  always_comb begin
    low_found = 1'b0;
    low_chan  = '0;
    nxt_found = 1'b0;
    nxt_chan  = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (live[c]) begin
        low_found = 1'b1;
        low_chan  = CurW'(c);
        if (c > int'(cur_q)) begin
          nxt_found = 1'b1;
          nxt_chan  = CurW'(c);
        end
      end
    end
  end

  // division by the sample count as a multiply by its reciprocal
  assign prod = {{RecipW{1'b0}}, sum_q} * {{SumW{1'b0}}, Recip};

  // memory addresses
  assign wr_addr = AddrW'(AddrW'(cur_q) * AddrW'(SAMPLES)
                   + AddrW'(SAMPLES - 1) - AddrW'(left_q));
  assign rd_addr = AddrW'(AddrW'(rch_q) * AddrW'(SAMPLES) + AddrW'(cnt_q));

  // sequencer and shared accumulator
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    left_d      = left_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    sel_d       = sel_q;
    start_d     = start_q;
    wr_en       = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StExec;
        end
      end
      StExec: begin
        sel_d   = 1'b0;
        start_d = 1'b0;
        sum_d   = '0;
        cnt_d   = '0;
        if (op_q == OpRead) begin
          state_d = (int'(rch_q) < CHANNELS) ? StRd : StFin;
        end else begin
          state_d = StFin;
          if (!cur_valid_q) begin
            if (low_found) begin
              cur_d       = low_chan;
              cur_valid_d = 1'b1;
              left_d      = LeftW'(SAMPLES);
            end
          end else if (left_q >= LeftW'(SAMPLES)) begin
            sel_d   = 1'b1;
            start_d = 1'b1;
            left_d  = LeftW'(SAMPLES - 1);
          end else begin
            wr_en = 1'b1;
            if (left_q != '0) begin
              start_d = 1'b1;
              left_d  = left_q - 1'b1;
            end else begin
              left_d = LeftW'(SAMPLES);
              if (nxt_found) begin
                cur_d = nxt_chan;
              end else begin
                cur_d       = '0;
                cur_valid_d = 1'b0;
              end
            end
          end
        end
      end
      StRd: begin
        state_d = StAdd;
      end
      StAdd: begin
        sum_d = sum_q + SumW'(rd_data);
        if (cnt_q == CntW'(SAMPLES - 1)) begin
          cnt_d   = '0;
          state_d = StDiv;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = StRd;
        end
      end
      StDiv: begin
        sum_d   = prod[DivSh +: SumW];
        state_d = StFin;
      end
      StFin: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      left_q      <= LeftW'(SAMPLES);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      left_q      <= left_d;
      cnt_q       <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request capture, datapath and result registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= operation_i;
      conv_q <= SAMPLE_BITS'(conversion_value_i);
      rch_q  <= read_channel_i;
    end
    sum_q   <= sum_d;
    sel_q   <= sel_d;
    start_q <= start_d;
    if (out_load) begin
      out_sel_q   <= sel_q;
      out_start_q <= start_q;
      out_chan_q  <= cur_valid_q ? ChanW'(cur_q) : '0;
      out_idle_q  <= !cur_valid_q;
      out_avg_q   <= AvgW'(sum_q[SAMPLE_BITS-1:0]);
    end
  end

  // per-channel sample memory
  acsa_sample_store #(
    .Depth (Depth),
    .Width (SAMPLE_BITS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (conv_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o        = out_valid_q;
  assign select_channel_o   = out_sel_q;
  assign start_conversion_o = out_start_q;
  assign active_channel_o   = out_chan_q;
  assign scan_idle_o        = out_idle_q;
  assign average_o          = out_avg_q;

endmodule

`default_nettype wire
